[hw/rtl/ray_triangle_intersect_unit_defines.svh]
// assertion macros used by the checker file
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define RTI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, widths and register codes of the ray / triangle unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  // fixed point format of coordinates
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_BITS = 16;

  // datapath widths
  localparam int unsigned VEC_W    = COORD_W + 1;
  localparam int unsigned OPB_W    = 34;
  localparam int unsigned PROD_W   = VEC_W + OPB_W;
  localparam int unsigned CROSS_W  = 2 * VEC_W;
  localparam int unsigned ACC_W    = 104;
  localparam int unsigned DIST_W   = 31;
  localparam int unsigned DIV_W    = ACC_W + DIST_W;
  localparam int unsigned EPS_W    = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_EPS   = 3'd6
  } cfg_reg_e;

  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    vec_t z;
  } vec3_t;

  // one triangle after edge setup
  typedef struct packed {
    vec3_t e1;
    vec3_t e2;
    vec3_t s;
    logic  last;
  } edge_item_t;

  // sign extend the low COORD_W bits of a raw coordinate
  function automatic vec_t sext_coord(input logic [CFG_DATA_W-1:0] raw);
    logic signed [CFG_DATA_W-1:0] sh;
    sh = $signed(raw << (CFG_DATA_W - COORD_W)) >>> (CFG_DATA_W - COORD_W);
    return vec_t'(sh);
  endfunction

endpackage

[hw/rtl/rti_intf.sv]
// ----------------------------------------------------------------------------
// rti_intf
// Triangle and result channel interfaces, valid / ready handshake.
// ----------------------------------------------------------------------------
interface rti_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] v0_x;
  logic signed [31:0] v0_y;
  logic signed [31:0] v0_z;
  logic signed [31:0] v1_x;
  logic signed [31:0] v1_y;
  logic signed [31:0] v1_z;
  logic signed [31:0] v2_x;
  logic signed [31:0] v2_y;
  logic signed [31:0] v2_z;
  logic               last_triangle;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, last_triangle, input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, last_triangle, output ready);
endinterface

interface rti_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] hit_distance;
  logic        any_hit;
  logic [30:0] closest_distance;
  logic        query_done;

  modport source (output valid, hit, hit_distance, any_hit, closest_distance,
                  query_done, input ready);
  modport sink (input valid, hit, hit_distance, any_hit, closest_distance,
                query_done, output ready);
  modport monitor (input valid, ready, hit, hit_distance, any_hit,
                   closest_distance, query_done);
endinterface

[hw/rtl/rti_front.sv]
// ----------------------------------------------------------------------------
// rti_front
// Accepts triangle beats and forms edge1, edge2 and origin minus v0.
// ----------------------------------------------------------------------------
module rti_front (
  rti_tri_if.sink            tri_i,
  input  rti_pkg::vec3_t     org_i,
  input  logic               full_i,
  output logic               push_o,
  output rti_pkg::edge_item_t item_o
);
  import rti_pkg::*;

  vec3_t v0, v1, v2;

  // accept whenever the queue has room
  assign tri_i.ready = !full_i;
  assign push_o      = tri_i.valid && !full_i;

  // sign extend vertices
  always_comb begin
    v0.x = sext_coord(tri_i.v0_x);
    v0.y = sext_coord(tri_i.v0_y);
    v0.z = sext_coord(tri_i.v0_z);
    v1.x = sext_coord(tri_i.v1_x);
    v1.y = sext_coord(tri_i.v1_y);
    v1.z = sext_coord(tri_i.v1_z);
    v2.x = sext_coord(tri_i.v2_x);
    v2.y = sext_coord(tri_i.v2_y);
    v2.z = sext_coord(tri_i.v2_z);
  end

  // edge setup, values stay inside VEC_W bits
  always_comb begin
    item_o.e1.x = v1.x - v0.x;
    item_o.e1.y = v1.y - v0.y;
    item_o.e1.z = v1.z - v0.z;
    item_o.e2.x = v2.x - v0.x;
    item_o.e2.y = v2.y - v0.y;
    item_o.e2.z = v2.z - v0.z;
    item_o.s.x  = org_i.x - v0.x;
    item_o.s.y  = org_i.y - v0.y;
    item_o.s.z  = org_i.z - v0.z;
    item_o.last = tri_i.last_triangle;
  end

endmodule

[hw/rtl/rti_queue.sv]
// ----------------------------------------------------------------------------
// rti_queue
// Small FIFO of set-up triangles between front and back.
// ----------------------------------------------------------------------------
module rti_queue #(
  parameter int unsigned DEPTH = rti_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rti_pkg::edge_item_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rti_pkg::edge_item_t head_o
);
  import rti_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  edge_item_t            mem_q [DEPTH];
  logic [PTR_W-1:0]      wptr_q, rptr_q;
  logic [CNT_W-1:0]      cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/rti_back.sv]
// ----------------------------------------------------------------------------
// rti_back
// Shared multiply-accumulate sequencer, hit tests, restoring divider for t
// and closest-hit tracking.
// ----------------------------------------------------------------------------
module rti_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  rti_pkg::edge_item_t          head_i,
  output logic                         pop_o,
  input  rti_pkg::vec3_t               dir_i,
  input  logic [rti_pkg::EPS_W-1:0]    eps_i,
  rti_res_if.source                    res_o
);
  import rti_pkg::*;

  localparam int unsigned NUM_UOPS = 36;
  localparam int unsigned UCNT_W   = $clog2(NUM_UOPS);
  localparam int unsigned K_W      = $clog2(DIST_W);

  typedef enum logic [1:0] {AV_DIR, AV_E1, AV_E2, AV_S} a_vec_e;
  typedef enum logic [2:0] {BS_E1, BS_E2, BS_P_LO, BS_P_HI, BS_Q_LO, BS_Q_HI} b_src_e;
  typedef enum logic [2:0] {D_P, D_Q, D_DET, D_U, D_V, D_T} dst_e;

  typedef struct packed {
    a_vec_e     a_vec;
    logic [1:0] a_c;
    b_src_e     b_src;
    logic [1:0] b_c;
    logic       neg;
    logic       first;
    logic       last;
    dst_e       dst;
    logic [1:0] dst_c;
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_NEG, ST_CHK1, ST_CHK2, ST_SAT, ST_DIV, ST_FIN
  } state_e;

  function automatic uop_t mk(a_vec_e av, logic [1:0] ac, b_src_e bs, logic [1:0] bc,
                              logic ng, logic fi, logic la, dst_e ds, logic [1:0] dc);
    uop_t u;
    u.a_vec = av; u.a_c = ac; u.b_src = bs; u.b_c = bc;
    u.neg = ng; u.first = fi; u.last = la; u.dst = ds; u.dst_c = dc;
    return u;
  endfunction

  // product schedule: P = dir x e2, Q = s x e1, then det, u, v, t
  function automatic uop_t uop_at(input logic [UCNT_W-1:0] n);
    uop_t u;
    case (n)
      6'd0:  u = mk(AV_DIR, 2'd1, BS_E2, 2'd2, 1'b0, 1'b1, 1'b0, D_P, 2'd0);
      6'd1:  u = mk(AV_DIR, 2'd2, BS_E2, 2'd1, 1'b1, 1'b0, 1'b1, D_P, 2'd0);
      6'd2:  u = mk(AV_DIR, 2'd2, BS_E2, 2'd0, 1'b0, 1'b1, 1'b0, D_P, 2'd1);
      6'd3:  u = mk(AV_DIR, 2'd0, BS_E2, 2'd2, 1'b1, 1'b0, 1'b1, D_P, 2'd1);
      6'd4:  u = mk(AV_DIR, 2'd0, BS_E2, 2'd1, 1'b0, 1'b1, 1'b0, D_P, 2'd2);
      6'd5:  u = mk(AV_DIR, 2'd1, BS_E2, 2'd0, 1'b1, 1'b0, 1'b1, D_P, 2'd2);
      6'd6:  u = mk(AV_S,   2'd1, BS_E1, 2'd2, 1'b0, 1'b1, 1'b0, D_Q, 2'd0);
      6'd7:  u = mk(AV_S,   2'd2, BS_E1, 2'd1, 1'b1, 1'b0, 1'b1, D_Q, 2'd0);
      6'd8:  u = mk(AV_S,   2'd2, BS_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_Q, 2'd1);
      6'd9:  u = mk(AV_S,   2'd0, BS_E1, 2'd2, 1'b1, 1'b0, 1'b1, D_Q, 2'd1);
      6'd10: u = mk(AV_S,   2'd0, BS_E1, 2'd1, 1'b0, 1'b1, 1'b0, D_Q, 2'd2);
      6'd11: u = mk(AV_S,   2'd1, BS_E1, 2'd0, 1'b1, 1'b0, 1'b1, D_Q, 2'd2);
      6'd12: u = mk(AV_E1,  2'd0, BS_P_LO, 2'd0, 1'b0, 1'b1, 1'b0, D_DET, 2'd0);
      6'd13: u = mk(AV_E1,  2'd0, BS_P_HI, 2'd0, 1'b0, 1'b0, 1'b0, D_DET, 2'd0);
      6'd14: u = mk(AV_E1,  2'd1, BS_P_LO, 2'd1, 1'b0, 1'b0, 1'b0, D_DET, 2'd0);
      6'd15: u = mk(AV_E1,  2'd1, BS_P_HI, 2'd1, 1'b0, 1'b0, 1'b0, D_DET, 2'd0);
      6'd16: u = mk(AV_E1,  2'd2, BS_P_LO, 2'd2, 1'b0, 1'b0, 1'b0, D_DET, 2'd0);
      6'd17: u = mk(AV_E1,  2'd2, BS_P_HI, 2'd2, 1'b0, 1'b0, 1'b1, D_DET, 2'd0);
      6'd18: u = mk(AV_S,   2'd0, BS_P_LO, 2'd0, 1'b0, 1'b1, 1'b0, D_U, 2'd0);
      6'd19: u = mk(AV_S,   2'd0, BS_P_HI, 2'd0, 1'b0, 1'b0, 1'b0, D_U, 2'd0);
      6'd20: u = mk(AV_S,   2'd1, BS_P_LO, 2'd1, 1'b0, 1'b0, 1'b0, D_U, 2'd0);
      6'd21: u = mk(AV_S,   2'd1, BS_P_HI, 2'd1, 1'b0, 1'b0, 1'b0, D_U, 2'd0);
      6'd22: u = mk(AV_S,   2'd2, BS_P_LO, 2'd2, 1'b0, 1'b0, 1'b0, D_U, 2'd0);
      6'd23: u = mk(AV_S,   2'd2, BS_P_HI, 2'd2, 1'b0, 1'b0, 1'b1, D_U, 2'd0);
      6'd24: u = mk(AV_DIR, 2'd0, BS_Q_LO, 2'd0, 1'b0, 1'b1, 1'b0, D_V, 2'd0);
      6'd25: u = mk(AV_DIR, 2'd0, BS_Q_HI, 2'd0, 1'b0, 1'b0, 1'b0, D_V, 2'd0);
      6'd26: u = mk(AV_DIR, 2'd1, BS_Q_LO, 2'd1, 1'b0, 1'b0, 1'b0, D_V, 2'd0);
      6'd27: u = mk(AV_DIR, 2'd1, BS_Q_HI, 2'd1, 1'b0, 1'b0, 1'b0, D_V, 2'd0);
      6'd28: u = mk(AV_DIR, 2'd2, BS_Q_LO, 2'd2, 1'b0, 1'b0, 1'b0, D_V, 2'd0);
      6'd29: u = mk(AV_DIR, 2'd2, BS_Q_HI, 2'd2, 1'b0, 1'b0, 1'b1, D_V, 2'd0);
      6'd30: u = mk(AV_E2,  2'd0, BS_Q_LO, 2'd0, 1'b0, 1'b1, 1'b0, D_T, 2'd0);
      6'd31: u = mk(AV_E2,  2'd0, BS_Q_HI, 2'd0, 1'b0, 1'b0, 1'b0, D_T, 2'd0);
      6'd32: u = mk(AV_E2,  2'd1, BS_Q_LO, 2'd1, 1'b0, 1'b0, 1'b0, D_T, 2'd0);
      6'd33: u = mk(AV_E2,  2'd1, BS_Q_HI, 2'd1, 1'b0, 1'b0, 1'b0, D_T, 2'd0);
      6'd34: u = mk(AV_E2,  2'd2, BS_Q_LO, 2'd2, 1'b0, 1'b0, 1'b0, D_T, 2'd0);
      default: u = mk(AV_E2, 2'd2, BS_Q_HI, 2'd2, 1'b0, 1'b0, 1'b1, D_T, 2'd0);
    endcase
    return u;
  endfunction

  state_e                     state_q;
  logic [UCNT_W-1:0]          cnt_q;

  vec_t                       dir_a [3];
  vec_t                       e1_q [3];
  vec_t                       e2_q [3];
  vec_t                       s_q [3];
  logic                       last_q;
  logic signed [CROSS_W-1:0]  p_q [3];
  logic signed [CROSS_W-1:0]  q_q [3];
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q, det_q, u_q, v_q, t_q;
  logic                       ok_q;
  logic [DIV_W-1:0]           num_q, dsh_q;
  logic [DIST_W-1:0]          quo_q, dist_q;
  logic                       hit_q;
  logic [DIST_W-1:0]          best_dist_q;
  logic                       best_valid_q;
  logic                       out_valid_q, out_hit_q, out_any_q, out_done_q;
  logic [DIST_W-1:0]          out_dist_q, out_best_q;

  uop_t                       uop;
  vec_t                       opa;
  logic signed [OPB_W-1:0]    opb;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    term, acc_base, acc_sum, lim, uv;
  logic                       chk1, chk2, div_ge, upd, new_valid;
  logic [DIST_W-1:0]          new_best;
  logic                       fin_fire;

  assign dir_a[0] = dir_i.x;
  assign dir_a[1] = dir_i.y;
  assign dir_a[2] = dir_i.z;

  assign pop_o = (state_q == ST_IDLE) && head_valid_i;

  // result leaves the final step when the output register is free
  assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || res_o.ready);

  // operand select and multiply
  always_comb begin
    uop = uop_at(cnt_q);
    case (uop.a_vec)
      AV_DIR:  opa = dir_a[uop.a_c];
      AV_E1:   opa = e1_q[uop.a_c];
      AV_E2:   opa = e2_q[uop.a_c];
      default: opa = s_q[uop.a_c];
    endcase
    case (uop.b_src)
      BS_E1:   opb = OPB_W'(e1_q[uop.b_c]);
      BS_E2:   opb = OPB_W'(e2_q[uop.b_c]);
      BS_P_LO: opb = $signed({2'b00, p_q[uop.b_c][31:0]});
      BS_P_HI: opb = p_q[uop.b_c][CROSS_W-1:32];
      BS_Q_LO: opb = $signed({2'b00, q_q[uop.b_c][31:0]});
      default: opb = q_q[uop.b_c][CROSS_W-1:32];
    endcase
    prod = opa * opb;
  end

  // accumulate, upper halves weigh 2^32
  always_comb begin
    term = ACC_W'(prod_q);
    if (uop.b_src inside {BS_P_HI, BS_Q_HI}) begin
      term = term <<< 32;
    end
    acc_base = uop.first ? '0 : acc_q;
    acc_sum  = uop.neg ? acc_base - term : acc_base + term;
  end

  // hit tests and divider compare
  always_comb begin
    lim    = (ACC_W'(eps_i) + ACC_W'(1)) <<< (2 * FRAC_BITS);
    uv     = u_q + v_q;
    chk1   = (det_q >= lim) && !u_q[ACC_W-1] && (det_q >= u_q);
    chk2   = ok_q && !v_q[ACC_W-1] && (det_q >= uv) && !t_q[ACC_W-1];
    div_ge = (num_q >= dsh_q);
  end

  // closest hit update
  always_comb begin
    upd       = hit_q && (!best_valid_q || (dist_q < best_dist_q));
    new_best  = upd ? dist_q : best_dist_q;
    new_valid = best_valid_q || hit_q;
  end

  // sequencer state, best distance and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      best_dist_q  <= '1;
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_hit_q    <= 1'b0;
      out_dist_q   <= '0;
      out_any_q    <= 1'b0;
      out_best_q   <= '1;
      out_done_q   <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_ACC;
        ST_ACC: begin
          if (cnt_q == UCNT_W'(NUM_UOPS - 1)) begin
            state_q <= ST_NEG;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_NEG:  state_q <= ST_CHK1;
        ST_CHK1: state_q <= ST_CHK2;
        ST_CHK2: state_q <= chk2 ? ST_SAT : ST_FIN;
        ST_SAT: begin
          if (div_ge) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q   <= UCNT_W'(DIST_W - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            out_hit_q   <= hit_q;
            out_dist_q  <= dist_q;
            out_any_q   <= new_valid;
            out_best_q  <= new_best;
            out_done_q  <= last_q;
            if (last_q) begin
              best_dist_q  <= '1;
              best_valid_q <= 1'b0;
            end else begin
              best_dist_q  <= new_best;
              best_valid_q <= new_valid;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          e1_q[0] <= head_i.e1.x; e1_q[1] <= head_i.e1.y; e1_q[2] <= head_i.e1.z;
          e2_q[0] <= head_i.e2.x; e2_q[1] <= head_i.e2.y; e2_q[2] <= head_i.e2.z;
          s_q[0]  <= head_i.s.x;  s_q[1]  <= head_i.s.y;  s_q[2]  <= head_i.s.z;
          last_q  <= head_i.last;
        end
      end
      ST_MUL: prod_q <= prod;
      ST_ACC: begin
        acc_q <= acc_sum;
        if (uop.last) begin
          case (uop.dst)
            D_P:     p_q[uop.dst_c] <= acc_sum[CROSS_W-1:0];
            D_Q:     q_q[uop.dst_c] <= acc_sum[CROSS_W-1:0];
            D_DET:   det_q <= acc_sum;
            D_U:     u_q   <= acc_sum;
            D_V:     v_q   <= acc_sum;
            default: t_q   <= acc_sum;
          endcase
        end
      end
      // fold the sign of det into all four sums
      ST_NEG: begin
        if (det_q[ACC_W-1]) begin
          det_q <= -det_q;
          u_q   <= -u_q;
          v_q   <= -v_q;
          t_q   <= -t_q;
        end
      end
      ST_CHK1: ok_q <= chk1;
      ST_CHK2: begin
        hit_q  <= chk2;
        dist_q <= '0;
        num_q  <= DIV_W'(t_q) << FRAC_BITS;
        dsh_q  <= DIV_W'(det_q) << DIST_W;
      end
      ST_SAT: begin
        if (div_ge) begin
          dist_q <= '1;
        end
        dsh_q <= dsh_q >> 1;
        quo_q <= '0;
      end
      // one quotient bit per cycle
      ST_DIV: begin
        if (div_ge) begin
          num_q <= num_q - dsh_q;
          quo_q[cnt_q[K_W-1:0]] <= 1'b1;
        end
        dsh_q <= dsh_q >> 1;
        if (cnt_q == '0) begin
          dist_q <= {quo_q[DIST_W-1:1], div_ge};
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.hit              = out_hit_q;
  assign res_o.hit_distance     = out_dist_q;
  assign res_o.any_hit          = out_any_q;
  assign res_o.closest_distance = out_best_q;
  assign res_o.query_done       = out_done_q;

endmodule

[hw/rtl/ray_triangle_intersect_unit.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit
// Exact fixed point ray / triangle test with closest hit over a run.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  tri_i     in    valid / ready    v0..v2 xyz, last_triangle
//  res_o     out   valid / ready    hit, distances, any_hit, query_done
//  cfg       in    cfg_we_i         cfg_idx_i, cfg_data_i
//
//  per triangle: one pop step, 36 products through one shared multiplier,
//  each a multiply step and an accumulate step, the test steps, the divider
//  and one output step; a miss and a saturated t skip the divider.
//  the front takes new triangles into a two-entry queue while the back works.
//  a finished result waits in the output register; the back stalls in its
//  final step until that register is free.
//  reset is asynchronous, active low, and clears the run state and queue.
module ray_triangle_intersect_unit #(
  parameter int unsigned Q_DEPTH = rti_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rti_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  rti_tri_if.sink                           tri_i,
  rti_res_if.source                         res_o
);
  import rti_pkg::*;

  logic [CFG_DATA_W-1:0] org_x_q, org_y_q, org_z_q;
  logic [CFG_DATA_W-1:0] dir_x_q, dir_y_q, dir_z_q;
  logic [EPS_W-1:0]      eps_q;

  vec3_t      org, dir;
  logic       push, full, head_valid, pop;
  edge_item_t push_item, head_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      dir_x_q <= '0;
      dir_y_q <= '0;
      dir_z_q <= CFG_DATA_W'(1) << FRAC_BITS;
      eps_q   <= EPS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ORG_X: org_x_q <= cfg_data_i;
        REG_ORG_Y: org_y_q <= cfg_data_i;
        REG_ORG_Z: org_z_q <= cfg_data_i;
        REG_DIR_X: dir_x_q <= cfg_data_i;
        REG_DIR_Y: dir_y_q <= cfg_data_i;
        REG_DIR_Z: dir_z_q <= cfg_data_i;
        REG_EPS:   eps_q   <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    org.x = sext_coord(org_x_q);
    org.y = sext_coord(org_y_q);
    org.z = sext_coord(org_z_q);
    dir.x = sext_coord(dir_x_q);
    dir.y = sext_coord(dir_y_q);
    dir.z = sext_coord(dir_z_q);
  end

  rti_front u_front (
    .tri_i  (tri_i),
    .org_i  (org),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  rti_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_item)
  );

  rti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .dir_i        (dir),
    .eps_i        (eps_q),
    .res_o        (res_o)
  );

endmodule

[hw/rtl/rti_checker.sv]
// ----------------------------------------------------------------------------
// rti_checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_triangle_intersect_unit_defines.svh"

module rti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        hit_i,
  input logic [30:0] hit_dist_i,
  input logic        any_hit_i,
  input logic [30:0] best_dist_i,
  input logic        done_i
);

  logic [64:0] res_beat;

  assign res_beat = {hit_i, hit_dist_i, any_hit_i, best_dist_i, done_i};

  // stalled beat holds
  `RTI_ASSERT_NXT(a_res_hold, valid_i && !ready_i, valid_i && $stable(res_beat), "beat changed under stall")

  // a miss reports zero distance
  `RTI_ASSERT_IMP(a_miss_zero, valid_i && !hit_i, hit_dist_i == 31'd0, "miss with nonzero distance")

  // a hit is part of the run and no closer than the best
  `RTI_ASSERT_IMP(a_hit_best, valid_i && hit_i, any_hit_i && (best_dist_i <= hit_dist_i), "hit not in closest")

  // an empty run reports the maximum distance
  `RTI_ASSERT_IMP(a_empty_max, valid_i && !any_hit_i, &best_dist_i, "empty run below maximum")

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (res_o.valid),
  .ready_i     (res_o.ready),
  .hit_i       (res_o.hit),
  .hit_dist_i  (res_o.hit_distance),
  .any_hit_i   (res_o.any_hit),
  .best_dist_i (res_o.closest_distance),
  .done_i      (res_o.query_done)
);
